>>> rtl/dhp_pkg.sv
// Shared types, codes and constants of the DDS header parser.
package dhp_pkg;

	// Most mip levels reported per header, capped at sixteen by the level field.
	localparam int MAX_MIPS   = 16;
	localparam int EMIT_LIMIT = (MAX_MIPS < 16) ? MAX_MIPS : 16;
	localparam int LEVEL_W    = 4;

	localparam int WORD_W     = 32;
	localparam int CNT_W      = 6;
	localparam int IDX_W      = 5;
	localparam logic [CNT_W-1:0] CNT_IDLE = 6'd32;

	// Word positions inside the header.
	localparam logic [IDX_W-1:0] W_MAGIC    = 5'd0;
	localparam logic [IDX_W-1:0] W_SIZE     = 5'd1;
	localparam logic [IDX_W-1:0] W_SFLAGS   = 5'd2;
	localparam logic [IDX_W-1:0] W_HEIGHT   = 5'd3;
	localparam logic [IDX_W-1:0] W_WIDTH    = 5'd4;
	localparam logic [IDX_W-1:0] W_PITCH    = 5'd5;
	localparam logic [IDX_W-1:0] W_DEPTH    = 5'd6;
	localparam logic [IDX_W-1:0] W_MIPS     = 5'd7;
	localparam logic [IDX_W-1:0] W_PF_SIZE  = 5'd19;
	localparam logic [IDX_W-1:0] W_PF_FLAGS = 5'd20;
	localparam logic [IDX_W-1:0] W_FOURCC   = 5'd21;
	localparam logic [IDX_W-1:0] W_BITCOUNT = 5'd22;
	localparam logic [IDX_W-1:0] W_CAPS2    = 5'd28;
	localparam logic [IDX_W-1:0] W_LAST     = 5'd31;

	localparam logic [WORD_W-1:0] MAGIC_DDS   = 32'h2053_4444;
	localparam logic [WORD_W-1:0] HDR_SIZE    = 32'd124;
	localparam logic [WORD_W-1:0] PF_SIZE     = 32'd32;
	localparam logic [WORD_W-1:0] SF_REQUIRED = 32'h0000_1007;
	localparam logic [WORD_W-1:0] SF_LINEAR   = 32'h0008_0000;
	localparam logic [WORD_W-1:0] SF_PITCH    = 32'h0000_0008;
	localparam logic [WORD_W-1:0] SF_DEPTH    = 32'h0080_0000;
	localparam logic [WORD_W-1:0] SF_MIPS     = 32'h0002_0000;
	localparam logic [WORD_W-1:0] PF_RGB      = 32'h0000_0040;
	localparam logic [WORD_W-1:0] PF_FOURCC   = 32'h0000_0004;
	localparam logic [WORD_W-1:0] PF_ALPHA    = 32'h0000_0001;
	localparam logic [WORD_W-1:0] CAPS2_CUBE  = 32'h0000_0200;
	localparam logic [23:0]       FOURCC_DXT  = 24'h54_5844;
	localparam logic [7:0]        DXT_LO      = 8'h31;
	localparam logic [7:0]        DXT_HI      = 8'h35;

	// Bit positions of the flag field.
	localparam int FB_LINEAR = 0;
	localparam int FB_PITCH  = 1;
	localparam int FB_VOLUME = 2;
	localparam int FB_MIPS   = 3;
	localparam int FB_RGB    = 4;
	localparam int FB_COMPR  = 5;
	localparam int FB_CUBE   = 6;
	localparam int FB_TRUNC  = 7;

	// Pixel path bits.
	localparam int PK_RGB    = 0;
	localparam int PK_FOURCC = 1;
	localparam int PK_ALPHA  = 2;

	localparam logic [3:0] STAT_OK           = 4'd0;
	localparam logic [3:0] STAT_MAGIC        = 4'd1;
	localparam logic [3:0] STAT_HDR_SIZE     = 4'd2;
	localparam logic [3:0] STAT_SURF_FLAGS   = 4'd3;
	localparam logic [3:0] STAT_PITCH_LINEAR = 4'd4;
	localparam logic [3:0] STAT_PF_SIZE      = 4'd5;
	localparam logic [3:0] STAT_NO_KIND      = 4'd6;
	localparam logic [3:0] STAT_ALPHA_FMT    = 4'd7;
	localparam logic [3:0] STAT_RGB_FMT      = 4'd8;
	localparam logic [3:0] STAT_FOURCC       = 4'd9;

	localparam logic [3:0] FMT_RGB8   = 4'd0;
	localparam logic [3:0] FMT_RGBX8  = 4'd1;
	localparam logic [3:0] FMT_R5G6B5 = 4'd2;
	localparam logic [3:0] FMT_L8     = 4'd3;
	localparam logic [3:0] FMT_RGBA8  = 4'd4;
	localparam logic [3:0] FMT_RGB5A1 = 4'd5;
	localparam logic [3:0] FMT_A8     = 4'd6;
	localparam logic [3:0] FMT_DXT1   = 4'd7;

	typedef enum logic [1:0] {
		ST_PARSE,
		ST_CALC,
		ST_PUT
	} dhp_state_t;

	typedef struct packed {
		logic               word_en;
		logic               restart;
		logic [IDX_W-1:0]   idx;
		logic               calc;
		logic               put;
		logic [LEVEL_W-1:0] level;
		logic               last;
	} dhp_cmd_t;

	typedef struct packed {
		logic               fail;
		logic               emit;
		logic               slot_free;
		logic [LEVEL_W-1:0] last_level;
	} dhp_stat_t;

endpackage

>>> rtl/dhp_in_if.sv
// Header word channel.
interface dhp_in_if;
	logic        valid;
	logic        ready;
	logic [31:0] header_word;
	logic        first_word;

	modport source (output valid, output header_word, output first_word, input ready);
	modport sink (input valid, input header_word, input first_word, output ready);
endinterface

>>> rtl/dhp_out_if.sv
// Result channel of the parser.
interface dhp_out_if;
	logic        valid;
	logic        ready;
	logic [3:0]  status;
	logic [3:0]  format_code;
	logic [7:0]  flag_bits;
	logic [31:0] width;
	logic [31:0] height;
	logic [31:0] depth;
	logic [31:0] pitch_or_linear_size;
	logic [3:0]  mip_level;
	logic [31:0] surface_size;
	logic        last;

	modport source (output valid, output status, output format_code, output flag_bits,
		output width, output height, output depth, output pitch_or_linear_size,
		output mip_level, output surface_size, output last, input ready);
	modport sink (input valid, input status, input format_code, input flag_bits,
		input width, input height, input depth, input pitch_or_linear_size,
		input mip_level, input surface_size, input last, output ready);
endinterface

>>> rtl/dhp_ctrl.sv
// Parser controller: word counter, mip level counter and emission state machine.
module dhp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               hdr_valid,
	input  logic               first_word,
	output logic               hdr_ready,
	input  dhp_pkg::dhp_stat_t stat,
	output dhp_pkg::dhp_cmd_t  cmd
);

	dhp_pkg::dhp_state_t             state_q;
	dhp_pkg::dhp_state_t             state_d;
	logic [dhp_pkg::CNT_W-1:0]       count_q;
	logic [dhp_pkg::LEVEL_W-1:0]     level_q;
	logic                            take;

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			dhp_pkg::ST_PARSE: begin
				if (stat.emit) begin
					state_d = dhp_pkg::ST_CALC;
				end
			end
			dhp_pkg::ST_CALC: begin
				state_d = dhp_pkg::ST_PUT;
			end
			dhp_pkg::ST_PUT: begin
				if (stat.slot_free) begin
					state_d = (level_q == stat.last_level) ? dhp_pkg::ST_PARSE
						: dhp_pkg::ST_CALC;
				end
			end
			default: begin
				state_d = dhp_pkg::ST_PARSE;
			end
		endcase
	end

	always_comb begin
		hdr_ready   = (state_q == dhp_pkg::ST_PARSE) && stat.slot_free;
		take        = hdr_valid && hdr_ready;
		// Words after a failure or past the end are taken and dropped.
		cmd.restart = take && first_word;
		cmd.word_en = take && (first_word || !count_q[dhp_pkg::CNT_W-1]);
		cmd.idx     = first_word ? dhp_pkg::W_MAGIC : count_q[dhp_pkg::IDX_W-1:0];
		cmd.calc    = (state_q == dhp_pkg::ST_CALC);
		cmd.put     = (state_q == dhp_pkg::ST_PUT) && stat.slot_free;
		cmd.level   = level_q;
		cmd.last    = (level_q == stat.last_level);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= dhp_pkg::ST_PARSE;
			count_q <= dhp_pkg::CNT_IDLE;
			level_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.word_en) begin
				count_q <= stat.fail ? dhp_pkg::CNT_IDLE
					: ({1'b0, cmd.idx} + dhp_pkg::CNT_W'(1));
			end
			if (stat.emit) begin
				level_q <= '0;
			end else if (cmd.put && !cmd.last) begin
				level_q <= level_q + dhp_pkg::LEVEL_W'(1);
			end
		end
	end

endmodule

>>> rtl/dhp_datapath.sv
// Parser datapath: header field registers, word checks, level size unit and result register.
module dhp_datapath (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        header_word,
	input  dhp_pkg::dhp_cmd_t  cmd,
	output dhp_pkg::dhp_stat_t stat,
	dhp_out_if.source          res
);

	logic [31:0] height_q, width_q, pitch_q, depth_q, mips_q;
	logic [31:0] height_d, width_d, pitch_d, depth_d, mips_d;
	logic [7:0]  flags_q, flags_d;
	logic [3:0]  format_q, format_d;
	logic [2:0]  bpp_q, bpp_d;
	logic [2:0]  kind_q, kind_d;
	logic [3:0]  err;
	logic        cubevol;
	logic        word_load;
	logic        out_valid_q;
	logic [31:0] mips_m1;

	// Size unit signals.
	logic [31:0] lvl_h, lvl_w, dim_h, dim_w, fac_a, fac_b;
	logic [63:0] prod_full;
	logic [4:0]  scale;
	logic [31:0] prod_s1;
	logic [4:0]  scale_s1;
	logic [36:0] size_full;

	always_comb begin
		height_d = cmd.restart ? '0 : height_q;
		width_d  = cmd.restart ? '0 : width_q;
		pitch_d  = cmd.restart ? '0 : pitch_q;
		depth_d  = cmd.restart ? '0 : depth_q;
		mips_d   = cmd.restart ? '0 : mips_q;
		flags_d  = cmd.restart ? '0 : flags_q;
		format_d = cmd.restart ? '0 : format_q;
		bpp_d    = cmd.restart ? '0 : bpp_q;
		kind_d   = cmd.restart ? '0 : kind_q;
		err      = dhp_pkg::STAT_OK;
		cubevol  = 1'b0;
		if (cmd.word_en) begin
			unique case (cmd.idx)
				dhp_pkg::W_MAGIC: begin
					if (header_word != dhp_pkg::MAGIC_DDS) begin
						err = dhp_pkg::STAT_MAGIC;
					end
				end
				dhp_pkg::W_SIZE: begin
					if (header_word != dhp_pkg::HDR_SIZE) begin
						err = dhp_pkg::STAT_HDR_SIZE;
					end
				end
				dhp_pkg::W_SFLAGS: begin
					if ((header_word & dhp_pkg::SF_REQUIRED) == '0) begin
						err = dhp_pkg::STAT_SURF_FLAGS;
					end else begin
						flags_d[dhp_pkg::FB_LINEAR] = |(header_word & dhp_pkg::SF_LINEAR);
						flags_d[dhp_pkg::FB_PITCH]  = |(header_word & dhp_pkg::SF_PITCH);
						flags_d[dhp_pkg::FB_VOLUME] = |(header_word & dhp_pkg::SF_DEPTH);
						flags_d[dhp_pkg::FB_MIPS]   = |(header_word & dhp_pkg::SF_MIPS);
					end
				end
				dhp_pkg::W_HEIGHT: begin
					height_d = header_word;
				end
				dhp_pkg::W_WIDTH: begin
					width_d = header_word;
					if (flags_d[dhp_pkg::FB_LINEAR] && flags_d[dhp_pkg::FB_PITCH]) begin
						err = dhp_pkg::STAT_PITCH_LINEAR;
					end
				end
				dhp_pkg::W_PITCH: begin
					pitch_d = header_word;
				end
				dhp_pkg::W_DEPTH: begin
					depth_d = flags_d[dhp_pkg::FB_VOLUME] ? header_word : '0;
				end
				dhp_pkg::W_MIPS: begin
					mips_d = flags_d[dhp_pkg::FB_MIPS] ? header_word : 32'd1;
				end
				dhp_pkg::W_PF_SIZE: begin
					if (header_word != dhp_pkg::PF_SIZE) begin
						err = dhp_pkg::STAT_PF_SIZE;
					end
				end
				dhp_pkg::W_PF_FLAGS: begin
					if (|(header_word & dhp_pkg::PF_RGB)) begin
						kind_d = '0;
						kind_d[dhp_pkg::PK_RGB]   = 1'b1;
						kind_d[dhp_pkg::PK_ALPHA] = |(header_word & dhp_pkg::PF_ALPHA);
						flags_d[dhp_pkg::FB_RGB]  = 1'b1;
					end else if (|(header_word & dhp_pkg::PF_FOURCC)) begin
						kind_d = '0;
						kind_d[dhp_pkg::PK_FOURCC] = 1'b1;
						flags_d[dhp_pkg::FB_COMPR] = 1'b1;
					end else begin
						err = dhp_pkg::STAT_NO_KIND;
					end
				end
				dhp_pkg::W_FOURCC: begin
					if (kind_d[dhp_pkg::PK_FOURCC]) begin
						if (header_word[23:0] == dhp_pkg::FOURCC_DXT
							&& header_word[31:24] >= dhp_pkg::DXT_LO
							&& header_word[31:24] <= dhp_pkg::DXT_HI) begin
							// DXT1 through DXT5 map onto consecutive codes.
							format_d = dhp_pkg::FMT_DXT1
								+ header_word[27:24] - dhp_pkg::DXT_LO[3:0];
						end else begin
							err = dhp_pkg::STAT_FOURCC;
						end
					end
				end
				dhp_pkg::W_BITCOUNT: begin
					if (kind_d[dhp_pkg::PK_RGB]) begin
						if (kind_d[dhp_pkg::PK_ALPHA]) begin
							if (header_word == 32'd32) begin
								format_d = dhp_pkg::FMT_RGBA8;
								bpp_d    = 3'd4;
							end else if (header_word == 32'd16) begin
								format_d = dhp_pkg::FMT_RGB5A1;
								bpp_d    = 3'd2;
							end else if (header_word == 32'd8) begin
								format_d = dhp_pkg::FMT_A8;
								bpp_d    = 3'd1;
							end else begin
								err = dhp_pkg::STAT_ALPHA_FMT;
							end
						end else begin
							if (header_word == 32'd24) begin
								format_d = dhp_pkg::FMT_RGB8;
								bpp_d    = 3'd3;
							end else if (header_word == 32'd32) begin
								format_d = dhp_pkg::FMT_RGBX8;
								bpp_d    = 3'd4;
							end else if (header_word == 32'd16) begin
								format_d = dhp_pkg::FMT_R5G6B5;
								bpp_d    = 3'd2;
							end else if (header_word == 32'd8) begin
								format_d = dhp_pkg::FMT_L8;
								bpp_d    = 3'd1;
							end else begin
								err = dhp_pkg::STAT_RGB_FMT;
							end
						end
					end
				end
				dhp_pkg::W_CAPS2: begin
					if (|(header_word & dhp_pkg::CAPS2_CUBE)) begin
						flags_d[dhp_pkg::FB_CUBE] = 1'b1;
					end
				end
				dhp_pkg::W_LAST: begin
					if (flags_d[dhp_pkg::FB_CUBE] || flags_d[dhp_pkg::FB_VOLUME]) begin
						cubevol = 1'b1;
					end else if (mips_d > 32'(dhp_pkg::EMIT_LIMIT)) begin
						flags_d[dhp_pkg::FB_TRUNC] = 1'b1;
					end
				end
				default: begin
				end
			endcase
		end
	end

	// Index of the final level to report; a zero count still reports level zero.
	always_comb begin
		mips_m1 = mips_q - 32'd1;
		if (mips_q == '0) begin
			stat.last_level = '0;
		end else if (mips_q > 32'(dhp_pkg::EMIT_LIMIT)) begin
			stat.last_level = dhp_pkg::LEVEL_W'(dhp_pkg::EMIT_LIMIT - 1);
		end else begin
			stat.last_level = mips_m1[dhp_pkg::LEVEL_W-1:0];
		end
		stat.fail      = cmd.word_en && (err != dhp_pkg::STAT_OK);
		stat.emit      = cmd.word_en && (cmd.idx == dhp_pkg::W_LAST) && !cubevol;
		stat.slot_free = !out_valid_q || res.ready;
		word_load      = cmd.word_en && ((err != dhp_pkg::STAT_OK) || cubevol);
	end

	// Level size: block or pixel counts multiplied, then the registered product scaled.
	always_comb begin
		lvl_h = height_q >> cmd.level;
		lvl_w = width_q >> cmd.level;
		dim_h = (lvl_h == '0) ? 32'd1 : lvl_h;
		dim_w = (lvl_w == '0) ? 32'd1 : lvl_w;
		if (flags_q[dhp_pkg::FB_COMPR]) begin
			fac_a = ((dim_w >> 2) == '0) ? 32'd1 : (dim_w >> 2);
			fac_b = ((dim_h >> 2) == '0) ? 32'd1 : (dim_h >> 2);
			scale = (format_q == dhp_pkg::FMT_DXT1) ? 5'd8 : 5'd16;
		end else begin
			fac_a = dim_w;
			fac_b = dim_h;
			scale = {2'b00, bpp_q};
		end
		prod_full = 64'(fac_a) * 64'(fac_b);
		size_full = 37'(prod_s1) * 37'(scale_s1);
	end

	always_ff @(posedge clk) begin
		if (cmd.calc) begin
			prod_s1  <= prod_full[31:0];
			scale_s1 <= scale;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			height_q <= '0;
			width_q  <= '0;
			pitch_q  <= '0;
			depth_q  <= '0;
			mips_q   <= '0;
			flags_q  <= '0;
			format_q <= '0;
			bpp_q    <= '0;
			kind_q   <= '0;
		end else begin
			height_q <= height_d;
			width_q  <= width_d;
			pitch_q  <= pitch_d;
			depth_q  <= depth_d;
			mips_q   <= mips_d;
			flags_q  <= flags_d;
			format_q <= format_d;
			bpp_q    <= bpp_d;
			kind_q   <= kind_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (word_load || cmd.put) begin
			out_valid_q <= 1'b1;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (word_load || cmd.put) begin
			res.status               <= err;
			res.format_code          <= format_d;
			res.flag_bits            <= flags_d;
			res.width                <= width_d;
			res.height               <= height_d;
			res.depth                <= depth_d;
			res.pitch_or_linear_size <= pitch_d;
			res.mip_level            <= word_load ? '0 : cmd.level;
			res.surface_size         <= word_load ? '0 : size_full[31:0];
			res.last                 <= word_load ? 1'b1 : cmd.last;
		end
	end

	assign res.valid = out_valid_q;

endmodule

>>> rtl/dds_header_parser.sv
// Top level of the DDS texture header parser.
//
// The parser takes the 32 words of a DDS header, one transfer per word,
// starting with the magic word marked by first_word, and reports the
// result of the parse on the result channel. A header word is taken every
// clock cycle whenever the result register is empty or is being drained in
// the same cycle, so a well-formed header streams in at one word per cycle.
// A word that fails a check ends the parse with one status result, issued
// with that word; further words are accepted and dropped until the next
// first_word. Any first_word restarts the parse, whatever was in progress.
// On word 31 a cube map or volume gives a single result with zero size.
// A plain 2D surface gives one result per mip level, up to sixteen, and
// each level passes through the shared size unit in two steps: the 32x32
// multiply of the block or pixel counts, then the scale by bytes per
// pixel or per block. The header channel holds ready low during this
// emission, so the word after a mipped header waits for every level.
// A count above the limit sets the truncated flag in every result.
module dds_header_parser (
	input logic       clk,
	input logic       arst_n,
	dhp_in_if.sink    hdr,
	dhp_out_if.source res
);

	dhp_pkg::dhp_cmd_t  cmd;
	dhp_pkg::dhp_stat_t stat;

	// The controller sequences words and mip levels; the datapath owns every field.
	dhp_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.hdr_valid  (hdr.valid),
		.first_word (hdr.first_word),
		.hdr_ready  (hdr.ready),
		.stat       (stat),
		.cmd        (cmd)
	);

	dhp_datapath u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.header_word (hdr.header_word),
		.cmd         (cmd),
		.stat        (stat),
		.res         (res)
	);

endmodule
